FILE: hdl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg: shared types and constants of the receive frame parser
// Byte codes, frame lengths, token and result formats, and the CRC-16 step.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'hFF;
  localparam logic [7:0] SYNC_SECOND  = 8'hCC;
  localparam logic [7:0] TYPE_MOTOR   = 8'h00;
  localparam logic [7:0] TYPE_ID_REQ  = 8'h08;
  localparam logic [7:0] TYPE_ID_SET  = 8'h06;

  localparam logic [3:0] LEN_MOTOR    = 4'd7;
  localparam logic [3:0] LEN_ID_REQ   = 4'd5;
  localparam logic [3:0] LEN_ID_SET   = 4'd9;
  localparam logic [3:0] POS_BODY     = 4'd3;

  localparam logic [1:0] KIND_MOTOR   = 2'd0;
  localparam logic [1:0] KIND_ID_REQ  = 2'd1;
  localparam logic [1:0] KIND_ID_SET  = 2'd2;

  localparam logic [7:0]  DRIVE_MAX    = 8'd200;
  localparam logic [7:0]  DRIVE_CENTER = 8'd100;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_TYPE,
    ST_BODY
  } front_state_t;

  typedef enum logic [1:0] {
    TOK_START,
    TOK_DATA,
    TOK_TRAIL,
    TOK_LAST
  } tok_op_t;

  typedef struct packed {
    tok_op_t    op;
    logic [1:0] kind;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    logic [1:0]        frame_kind;
    logic              crc_ok;
    logic              accepted;
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic [31:0]       id_value;
  } res_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/rx_frame_parser_crc16_core.sv
// ----------------------------------------------------------------------------
// rx_frame_parser_crc16_core: received frame parser with CRC-16 check
// Finds sync-framed commands in a byte stream and reports each frame.
// ----------------------------------------------------------------------------
// Input channel: one received byte per request on rx_byte, taken when push is
// high and full is low. The block takes one byte per cycle; full rises only
// when the token queue between the parser front and the CRC back end fills.
// Result channel: one request per complete frame, shown while empty is low and
// taken when pop is high. Results carry frame_kind, crc_ok, accepted, the two
// drives of a motor frame and the id of an id set frame.
// The token of a frame's last byte is queued and enters the result register
// when no result waits or the waiting one is popped. Throughput is one byte
// per cycle while full is low, set by the one-token-per-cycle CRC step in the
// back end. A waiting result stops the back end only at a frame's last byte.
// Reset clears the hunt state, empties the token queue and drops any waiting
// result. When the receiver stalls, the queue absorbs up to QUEUE_DEPTH tokens
// before full is raised.
// ----------------------------------------------------------------------------
module rx_frame_parser_crc16_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  logic              push,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        frame_kind,
  output logic              crc_ok,
  output logic              accepted,
  output logic signed [7:0] left_drive,
  output logic signed [7:0] right_drive,
  output logic [31:0]       id_value
);

  logic          in_valid;
  logic          ftok_valid;
  rfp_pkg::tok_t ftok;
  logic          q_empty;
  rfp_pkg::tok_t qtok;
  logic          qpop;
  logic          res_valid;
  rfp_pkg::res_t res;

  assign in_valid = push && !full;

  rfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .rx_byte   (rx_byte),
    .tok_valid (ftok_valid),
    .tok       (ftok)
  );

  rfp_token_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (ftok_valid),
    .wdata (ftok),
    .full  (full),
    .pop   (qpop),
    .rdata (qtok),
    .empty (q_empty)
  );

  rfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!q_empty),
    .tok       (qtok),
    .tok_pop   (qpop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty       = !res_valid;
  assign frame_kind  = res.frame_kind;
  assign crc_ok      = res.crc_ok;
  assign accepted    = res.accepted;
  assign left_drive  = res.left_drive;
  assign right_drive = res.right_drive;
  assign id_value    = res.id_value;

endmodule

FILE: hdl/rfp_front.sv
// ----------------------------------------------------------------------------
// rfp_front: sync hunt and byte classification
// Tracks the frame position; each frame byte after the sync pair becomes a
// token for the back end. Bytes outside a frame produce no token.
// ----------------------------------------------------------------------------
module rfp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    rx_byte,
  output logic          tok_valid,
  output rfp_pkg::tok_t tok
);

  rfp_pkg::front_state_t state, state_next;
  logic [3:0] pos, pos_next;
  logic [3:0] len, len_next;
  logic [4:0] pos_plus2;

  assign pos_plus2 = {1'b0, pos} + 5'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfp_pkg::ST_HUNT;
      pos   <= '0;
      len   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      len   <= len_next;
    end
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    len_next   = len;
    tok_valid  = 1'b0;
    tok.op     = rfp_pkg::TOK_DATA;
    tok.kind   = rfp_pkg::KIND_MOTOR;
    tok.data   = rx_byte;
    if (in_valid) begin
      case (state)
        rfp_pkg::ST_HUNT: begin
          if (rx_byte == rfp_pkg::SYNC_FIRST) begin
            state_next = rfp_pkg::ST_SYNC2;
          end
        end
        rfp_pkg::ST_SYNC2: begin
          if (rx_byte == rfp_pkg::SYNC_SECOND) begin
            state_next = rfp_pkg::ST_TYPE;
          end else if (rx_byte != rfp_pkg::SYNC_FIRST) begin
            state_next = rfp_pkg::ST_HUNT;
          end
        end
        rfp_pkg::ST_TYPE: begin
          state_next = rfp_pkg::ST_BODY;
          pos_next   = rfp_pkg::POS_BODY;
          tok_valid  = 1'b1;
          tok.op     = rfp_pkg::TOK_START;
          if (rx_byte == rfp_pkg::TYPE_MOTOR) begin
            len_next = rfp_pkg::LEN_MOTOR;
            tok.kind = rfp_pkg::KIND_MOTOR;
          end else if (rx_byte == rfp_pkg::TYPE_ID_REQ) begin
            len_next = rfp_pkg::LEN_ID_REQ;
            tok.kind = rfp_pkg::KIND_ID_REQ;
          end else if (rx_byte == rfp_pkg::TYPE_ID_SET) begin
            len_next = rfp_pkg::LEN_ID_SET;
            tok.kind = rfp_pkg::KIND_ID_SET;
          end else begin
            state_next = rfp_pkg::ST_HUNT;
            pos_next   = pos;
            tok_valid  = 1'b0;
          end
        end
        rfp_pkg::ST_BODY: begin
          if (pos >= len) begin
            state_next = rfp_pkg::ST_HUNT;
          end else if (pos_plus2 < {1'b0, len}) begin
            tok_valid = 1'b1;
            tok.op    = rfp_pkg::TOK_DATA;
            pos_next  = pos + 4'd1;
          end else if (pos_plus2 == {1'b0, len}) begin
            tok_valid = 1'b1;
            tok.op    = rfp_pkg::TOK_TRAIL;
            pos_next  = pos + 4'd1;
          end else begin
            tok_valid  = 1'b1;
            tok.op     = rfp_pkg::TOK_LAST;
            state_next = rfp_pkg::ST_HUNT;
          end
        end
        default: begin
          state_next = rfp_pkg::ST_HUNT;
        end
      endcase
    end
  end

endmodule

FILE: hdl/rfp_token_fifo.sv
// ----------------------------------------------------------------------------
// rfp_token_fifo: short token queue between front and back end
// A register queue with one write and one read port.
// ----------------------------------------------------------------------------
module rfp_token_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfp_pkg::tok_t wdata,
  output logic          full,
  input  logic          pop,
  output rfp_pkg::tok_t rdata,
  output logic          empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rfp_pkg::tok_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic do_push, do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/rfp_back.sv
// ----------------------------------------------------------------------------
// rfp_back: CRC, payload assembly and result register
// Consumes tokens, keeps the running CRC and payload, and forms one result
// when the last byte of a frame arrives.
// ----------------------------------------------------------------------------
module rfp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  input  rfp_pkg::tok_t tok,
  output logic          tok_pop,
  output logic          res_valid,
  output rfp_pkg::res_t res,
  input  logic          res_pop
);

  logic [1:0]    kind;
  logic [15:0]   crc;
  logic [31:0]   payload;
  logic [7:0]    trailer_high;
  logic [15:0]   crc_in;
  logic [15:0]   crc_next;
  logic [7:0]    m1, m2;
  logic          in_range;
  logic          is_last;
  rfp_pkg::res_t res_next;

  assign is_last  = (tok.op == rfp_pkg::TOK_LAST);
  assign tok_pop  = tok_valid && (!is_last || !res_valid || res_pop);
  assign crc_in   = (tok.op == rfp_pkg::TOK_START) ? 16'h0000 : crc;
  assign crc_next = rfp_pkg::crc16_step(crc_in, tok.data);
  assign m1       = payload[15:8];
  assign m2       = payload[7:0];
  assign in_range = (m1 <= rfp_pkg::DRIVE_MAX) && (m2 <= rfp_pkg::DRIVE_MAX);

  always_comb begin
    res_next.frame_kind  = kind;
    res_next.crc_ok      = ({trailer_high, tok.data} == crc);
    res_next.accepted    = 1'b1;
    res_next.left_drive  = '0;
    res_next.right_drive = '0;
    res_next.id_value    = '0;
    case (kind)
      rfp_pkg::KIND_MOTOR: begin
        res_next.accepted = res_next.crc_ok && in_range;
        if (in_range) begin
          res_next.left_drive  = rfp_pkg::DRIVE_CENTER - m1;
          res_next.right_drive = m2 - rfp_pkg::DRIVE_CENTER;
        end
      end
      rfp_pkg::KIND_ID_REQ: begin
        res_next.accepted = res_next.crc_ok;
      end
      default: begin
        res_next.id_value = payload;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      case (tok.op)
        rfp_pkg::TOK_START: begin
          kind    <= tok.kind;
          crc     <= crc_next;
          payload <= '0;
        end
        rfp_pkg::TOK_DATA: begin
          crc     <= crc_next;
          payload <= {payload[23:0], tok.data};
        end
        rfp_pkg::TOK_TRAIL: begin
          trailer_high <= tok.data;
        end
        default: begin
          res <= res_next;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tok_pop && is_last) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/rfp_checker.sv
// ----------------------------------------------------------------------------
// rfp_checker: port-level checks of the frame parser
// Watches the result channel and the result fields over time.
// ----------------------------------------------------------------------------
module rfp_checker (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input logic [1:0]        frame_kind,
  input logic              crc_ok,
  input logic              accepted,
  input logic signed [7:0] left_drive,
  input logic signed [7:0] right_drive,
  input logic [31:0]       id_value
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue not empty after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_kind) && $stable(crc_ok)
                          && $stable(accepted) && $stable(id_value)))
    else $error("Waiting result changed before it was taken.");

  a_drive_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_kind != rfp_pkg::KIND_MOTOR)
      |-> (left_drive == 8'sd0 && right_drive == 8'sd0))
    else $error("Drive values given for a frame that is not a motor frame.");

  a_id_set: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_kind == rfp_pkg::KIND_ID_SET) |-> accepted)
    else $error("Id set frame was not accepted.");

  a_id_req: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_kind == rfp_pkg::KIND_ID_REQ)
      |-> (accepted == crc_ok && id_value == 32'd0))
    else $error("Id request result does not follow its CRC check.");

endmodule

bind rx_frame_parser_crc16_core rfp_checker u_rfp_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .frame_kind  (frame_kind),
  .crc_ok      (crc_ok),
  .accepted    (accepted),
  .left_drive  (left_drive),
  .right_drive (right_drive),
  .id_value    (id_value)
);
